/* rtl/core/wrws_pkg.sv */
// ----------------------------------------------------------------------------
// Weekly relay window scheduler package
// Shared constants, codes and the stored entry layout of the scheduler core.
// ----------------------------------------------------------------------------
package wrws_pkg;

    localparam int DAYS              = 7;
    localparam int DAY_SECONDS       = 86400;
    localparam int WEEK_SECONDS      = 604800;
    // Signed width for times relative to the start of an entry's day.
    localparam int TIME_W            = 22;

    localparam int SLOTS_PER_DAY_DEF = 16;
    localparam int RELAY_COUNT_DEF   = 4;

    localparam logic [15:0] HEALTH_MIN_RST  = 16'd1280;
    localparam logic [15:0] TEMP_MAX_RST    = 16'd16640;
    localparam logic [7:0]  PROTECT_SEC_RST = 8'd3;
    localparam logic [6:0]  DAY_EN_RST      = 7'h7F;

    typedef enum logic [1:0] {
        ACT_WRITE_ENTRY = 2'd0,
        ACT_WRITE_DAY   = 2'd1,
        ACT_TICK        = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        CFG_HEALTH_MIN  = 2'd0,
        CFG_TEMP_MAX    = 2'd1,
        CFG_PROTECT_SEC = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [16:0] start_s;
        logic [16:0] end_s;
        logic [2:0]  offset;
        logic [1:0]  relay;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

/* rtl/core/wrws_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wrws_ram #(
    parameter int WIDTH = wrws_pkg::ENTRY_W,
    parameter int DEPTH = wrws_pkg::DAYS * wrws_pkg::SLOTS_PER_DAY_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/weekly_relay_window_scheduler_core.sv */
// ----------------------------------------------------------------------------
// Weekly relay window scheduler core
// Keeps a week of relay on-windows and a day enable mask, and on each tick
// scans yesterday's and today's entries to decide which relays to switch.
// ----------------------------------------------------------------------------
//  Channel  | Handshake            | Contents
//  ---------+----------------------+------------------------------------------
//  cfg      | cfg_we               | cfg_index, cfg_data (register write)
//  in       | in_valid / in_ready  | action, day, slot, ... temperature
//  out      | out_valid / out_ready| relay_want, switch masks, ring result
//
// A tick reads one entry per cycle from the entry RAM and passes through
// the accept cycle, the read cycles over yesterday's and today's slots,
// the drain of the evaluation pipeline and the finish cycle. An entry or
// day enable write goes from the accept cycle straight to the finish state.
// in_ready is high only while the core is idle; a result waiting in the
// output register does not block the next transaction, but the finish cycle
// waits for the register to free.
// Entry valid bits live in flip-flops cleared by reset, so no RAM clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
module weekly_relay_window_scheduler_core #(
    parameter int SLOTS_PER_DAY = wrws_pkg::SLOTS_PER_DAY_DEF,
    parameter int RELAY_COUNT   = wrws_pkg::RELAY_COUNT_DEF
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic [2:0]         day,
    input  logic [3:0]         slot,
    input  logic               flag,
    input  logic [16:0]        time_of_day,
    input  logic [16:0]        end_time_of_day,
    input  logic [2:0]         end_day_offset,
    input  logic [1:0]         relay,
    input  logic [31:0]        now_ms,
    input  logic [3:0]         relay_now,
    input  logic [15:0]        health,
    input  logic signed [15:0] temperature,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [3:0]         relay_want,
    output logic [3:0]         relay_switch_on,
    output logic [3:0]         relay_switch_off,
    output logic               ring_done,
    output logic [31:0]        ring_ms
);

    localparam int DEPTH = wrws_pkg::DAYS * SLOTS_PER_DAY;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW    = (SLOTS_PER_DAY > 1) ? $clog2(SLOTS_PER_DAY) : 1;
    localparam int TW    = wrws_pkg::TIME_W;

    localparam logic [3:0]    RELAY_MASK = 4'((1 << RELAY_COUNT) - 1);
    localparam logic [2:0]    RELAY_LIM  = 3'(RELAY_COUNT);
    localparam logic [6:0]    SLOTS_LIM  = 7'(SLOTS_PER_DAY);
    localparam logic [AW-1:0] SLOTS_A    = AW'(SLOTS_PER_DAY);
    localparam logic [SW-1:0] SLOT_LAST  = SW'(SLOTS_PER_DAY - 1);

    localparam logic [TW-1:0] DAY_U      = TW'(wrws_pkg::DAY_SECONDS);
    localparam logic signed [TW-1:0] DAY_T     = TW'(wrws_pkg::DAY_SECONDS);
    localparam logic signed [TW-1:0] WEEK_T    = TW'(wrws_pkg::WEEK_SECONDS);
    localparam logic signed [TW-1:0] SIX_DAY_T = TW'(6 * wrws_pkg::DAY_SECONDS);
    localparam logic signed [TW-1:0] WK_MON_T  =
        TW'(wrws_pkg::WEEK_SECONDS - 6 * wrws_pkg::DAY_SECONDS);
    localparam logic signed [TW-1:0] WK_OTH_T  =
        TW'(wrws_pkg::WEEK_SECONDS + wrws_pkg::DAY_SECONDS);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Configuration and persistent state.
    logic [15:0]        health_min_reg;
    logic signed [15:0] temp_max_reg;
    logic [7:0]         protect_sec_reg;
    logic [6:0]         day_en_reg;
    logic [DEPTH-1:0]   entry_valid_reg;
    logic [31:0]        stamp_reg;

    // Context of the transaction in progress.
    logic               is_tick_reg;
    logic               protect_reg;
    logic [31:0]        now_ms_reg;
    logic [3:0]         relay_now_reg;
    logic [2:0]         day_y_reg;
    logic [2:0]         day_t_reg;
    logic signed [TW-1:0] now_y_reg, now_t_reg;
    logic signed [TW-1:0] wk_y_reg, wk_t_reg;
    logic signed [TW-1:0] late_y_reg, late_t_reg;

    // Scan sequencer.
    logic               pass_reg;
    logic [SW-1:0]      slot_cnt_reg;
    logic               drain_reg;

    // Evaluation pipeline.
    logic               p1_v_reg, p1_pass_reg;
    logic               p2_v_reg, p2_pass_reg;
    logic signed [TW-1:0] p2_start_reg, p2_end_reg;
    logic [1:0]         p2_relay_reg;
    logic [3:0]         want_reg, want_next;

    logic               out_valid_reg;
    logic [3:0]         want_out_reg, on_out_reg, off_out_reg;
    logic               ring_done_reg;
    logic [31:0]        ring_ms_reg;

    logic               in_fire;
    logic               out_free;
    logic               slot_ok;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;
    wrws_pkg::entry_t   wr_entry;
    wrws_pkg::entry_t   rd_entry;
    logic [2:0]         scan_day;
    logic [AW-1:0]      rd_addr;
    logic               rd_elig;

    logic [2:0]           today, yesterday;
    logic signed [TW-1:0] tod_s, prot_s, now_y;

    logic [TW-1:0]        a_start, a_end0, a_end;
    logic [1:0]           a_relay;

    logic signed [TW-1:0] b_now, b_wk, b_late;
    logic                 b_in_win, b_in_wk, b_late_hit;

    logic [3:0]           want_m, rn_m, on_m, off_m;
    logic                 ring_hit;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign out_valid        = out_valid_reg;
    assign relay_want       = want_out_reg;
    assign relay_switch_on  = on_out_reg;
    assign relay_switch_off = off_out_reg;
    assign ring_done        = ring_done_reg;
    assign ring_ms          = ring_ms_reg;

    // ------------------------------------------------------------------
    // Entry writes
    // ------------------------------------------------------------------
    assign slot_ok  = ({3'b000, slot} < SLOTS_LIM) && (day != 3'd7);
    assign wr_addr  = AW'(day) * SLOTS_A + AW'(slot);
    assign wr_en    = in_fire && (action == wrws_pkg::ACT_WRITE_ENTRY) && slot_ok;
    assign wr_entry = '{start_s: time_of_day, end_s: end_time_of_day,
                        offset: end_day_offset, relay: relay};

    assign scan_day = pass_reg ? day_t_reg : day_y_reg;
    assign rd_addr  = AW'(scan_day) * SLOTS_A + AW'(slot_cnt_reg);
    assign rd_elig  = day_en_reg[scan_day] && entry_valid_reg[rd_addr];

    wrws_ram #(
        .WIDTH (wrws_pkg::ENTRY_W),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .raddr (rd_addr),
        .rdata (rd_entry)
    );

    // ------------------------------------------------------------------
    // Tick context: times are kept relative to the start of each scanned
    // day, so every entry compare works on its own start and end seconds.
    // ------------------------------------------------------------------
    always_comb
    begin
        today     = (day == 3'd7) ? 3'd0 : day;
        yesterday = (today == 3'd0) ? 3'd6 : today - 3'd1;
        tod_s     = $signed(TW'(time_of_day));
        prot_s    = $signed(TW'(protect_sec_reg));
        now_y     = (today == 3'd0) ? tod_s - SIX_DAY_T : tod_s + DAY_T;
    end

    // Stage A: absolute end of the window within the entry's frame.
    always_comb
    begin
        a_start = TW'(rd_entry.start_s);
        a_end0  = TW'(rd_entry.offset) * DAY_U + TW'(rd_entry.end_s);
        a_end   = (a_end0 <= a_start) ? a_end0 + DAY_U : a_end0;
        a_relay = ({1'b0, rd_entry.relay} < RELAY_LIM) ? rd_entry.relay : 2'd0;
    end

    // Stage B: window tests and the update of the wanted mask, in slot order.
    always_comb
    begin
        b_now      = p2_pass_reg ? now_t_reg  : now_y_reg;
        b_wk       = p2_pass_reg ? wk_t_reg   : wk_y_reg;
        b_late     = p2_pass_reg ? late_t_reg : late_y_reg;
        b_in_win   = (b_now >= p2_start_reg) && (b_now < p2_end_reg);
        b_in_wk    = (b_wk >= p2_start_reg) && (b_wk < p2_end_reg);
        b_late_hit = (b_late >= p2_start_reg);
        want_next  = want_reg;
        if (b_in_win)
        begin
            if ((p2_relay_reg == 2'd0) && protect_reg && b_late_hit)
            begin
                want_next[0] = 1'b0;
            end
            else
            begin
                want_next[p2_relay_reg] = 1'b1;
            end
        end
        if (b_in_wk)
        begin
            want_next[p2_relay_reg] = 1'b1;
        end
    end

    always_comb
    begin
        want_m   = want_reg & RELAY_MASK;
        rn_m     = relay_now_reg & RELAY_MASK;
        on_m     = want_m & ~rn_m;
        off_m    = ~want_m & rn_m;
        ring_hit = is_tick_reg && !on_m[0] && off_m[0] && (stamp_reg != 32'd0);
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = (action == wrws_pkg::ACT_TICK) ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                if (pass_reg && (slot_cnt_reg == SLOT_LAST))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            health_min_reg  <= wrws_pkg::HEALTH_MIN_RST;
            temp_max_reg    <= wrws_pkg::TEMP_MAX_RST;
            protect_sec_reg <= wrws_pkg::PROTECT_SEC_RST;
            day_en_reg      <= wrws_pkg::DAY_EN_RST;
            entry_valid_reg <= '0;
            stamp_reg       <= 32'd0;
            is_tick_reg     <= 1'b0;
            pass_reg        <= 1'b0;
            slot_cnt_reg    <= '0;
            drain_reg       <= 1'b0;
            p1_v_reg        <= 1'b0;
            p2_v_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    wrws_pkg::CFG_HEALTH_MIN:  health_min_reg  <= cfg_data;
                    wrws_pkg::CFG_TEMP_MAX:    temp_max_reg    <= $signed(cfg_data);
                    wrws_pkg::CFG_PROTECT_SEC: protect_sec_reg <= cfg_data[7:0];
                    default:
                    begin
                    end
                endcase
            end

            if (in_fire)
            begin
                is_tick_reg  <= (action == wrws_pkg::ACT_TICK);
                pass_reg     <= 1'b0;
                slot_cnt_reg <= '0;
                drain_reg    <= 1'b0;
                unique case (action)
                    wrws_pkg::ACT_WRITE_ENTRY:
                    begin
                        if (slot_ok)
                        begin
                            entry_valid_reg[wr_addr] <= flag;
                        end
                    end
                    wrws_pkg::ACT_WRITE_DAY:
                    begin
                        if (day != 3'd7)
                        begin
                            day_en_reg[day] <= flag;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == ST_SCAN)
            begin
                if (slot_cnt_reg == SLOT_LAST)
                begin
                    slot_cnt_reg <= '0;
                    pass_reg     <= 1'b1;
                end
                else
                begin
                    slot_cnt_reg <= slot_cnt_reg + SW'(1);
                end
            end

            if (state_reg == ST_DRAIN)
            begin
                drain_reg <= 1'b1;
            end

            p1_v_reg <= (state_reg == ST_SCAN) && rd_elig;
            p2_v_reg <= p1_v_reg;

            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (is_tick_reg)
                begin
                    if (on_m[0])
                    begin
                        stamp_reg <= now_ms_reg;
                    end
                    else if (off_m[0] && (stamp_reg != 32'd0))
                    begin
                        stamp_reg <= 32'd0;
                    end
                end
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            protect_reg   <= (health < health_min_reg) || (temperature > temp_max_reg);
            now_ms_reg    <= now_ms;
            relay_now_reg <= relay_now;
            day_y_reg     <= yesterday;
            day_t_reg     <= today;
            now_y_reg     <= now_y;
            now_t_reg     <= tod_s;
            wk_y_reg      <= (today == 3'd0) ? tod_s + WK_MON_T : tod_s + WK_OTH_T;
            wk_t_reg      <= tod_s + WEEK_T;
            late_y_reg    <= now_y - prot_s;
            late_t_reg    <= tod_s - prot_s;
            want_reg      <= 4'd0;
        end
        else if (p2_v_reg)
        begin
            want_reg <= want_next;
        end

        p1_pass_reg  <= pass_reg;
        p2_pass_reg  <= p1_pass_reg;
        p2_start_reg <= $signed(a_start);
        p2_end_reg   <= $signed(a_end);
        p2_relay_reg <= a_relay;

        // Writes and unused actions report all-zero results.
        if ((state_reg == ST_FINISH) && out_free)
        begin
            want_out_reg  <= is_tick_reg ? want_m : 4'd0;
            on_out_reg    <= is_tick_reg ? on_m : 4'd0;
            off_out_reg   <= is_tick_reg ? off_m : 4'd0;
            ring_done_reg <= ring_hit;
            ring_ms_reg   <= ring_hit ? now_ms_reg - stamp_reg : 32'd0;
        end
    end

endmodule

/* rtl/core/wrws_checker.sv */
// ----------------------------------------------------------------------------
// Weekly relay window scheduler port checker
// Watches the core's ports for result consistency and handshake behavior.
// ----------------------------------------------------------------------------
module wrws_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [3:0]  relay_want,
    input logic [3:0]  relay_switch_on,
    input logic [3:0]  relay_switch_off,
    input logic        ring_done,
    input logic [31:0] ring_ms
);

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(relay_want)
            && $stable(relay_switch_on) && $stable(relay_switch_off)
            && $stable(ring_done) && $stable(ring_ms))
        else $error("result changed while stalled");

    // Switch masks must agree with the wanted mask.
    a_masks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((relay_switch_on & ~relay_want) == 4'd0)
            && ((relay_switch_off & relay_want) == 4'd0))
        else $error("switch masks disagree with wanted relays");

    // A ring report only comes with the bell being switched off.
    a_ring: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ring_done |-> relay_switch_off[0] && !relay_want[0])
        else $error("ring reported without bell switch-off");

    // The core works on one transaction at a time.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted while busy");

endmodule

bind weekly_relay_window_scheduler_core wrws_checker u_wrws_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .relay_want       (relay_want),
    .relay_switch_on  (relay_switch_on),
    .relay_switch_off (relay_switch_off),
    .ring_done        (ring_done),
    .ring_ms          (ring_ms)
);
